>>> sv/psrb_pkg.sv
// ----------------------------------------------------------------------------
// psrb_pkg
// Shared types, boundary-ray constants and the square-root step for the
// polar sector range binner.
// ----------------------------------------------------------------------------
package psrb_pkg;

  // Boundary rays as round(sin t * 2^30), round(cos t * 2^30)
  localparam logic signed [31:0] K_SIN20 = 32'sd367241333;
  localparam logic signed [31:0] K_COS20 = 32'sd1008987269;
  localparam logic signed [31:0] K_SIN60 = 32'sd929887697;
  localparam logic signed [31:0] K_COS60 = 32'sd536870912;

  localparam logic [15:0] SEEN_NONE   = 16'hFFFF;
  localparam int          RANGE_W     = 16;
  localparam int          N_SECTOR    = 6;
  localparam int          OUT_W       = RANGE_W * N_SECTOR;
  localparam int          SQRT_STAGES = 8;   // two root bits per stage

  typedef enum logic [2:0] {
    SEC_NONE,
    SEC_FRONT_LEFT,
    SEC_FRONT,
    SEC_FRONT_RIGHT,
    SEC_LEFT,
    SEC_RIGHT,
    SEC_REAR
  } sector_t;

  // Restoring square-root state: partial remainder, partial root, radicand
  // bits still to be consumed (top pair first).
  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
    logic [31:0] q;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       r;
    logic [19:0] rem_sh;
    logic [19:0] trial;
    rem_sh = {s.rem, s.q[31:30]};
    trial  = {2'b00, s.root, 2'b01};
    if (rem_sh >= trial) begin
      r.rem  = 18'(rem_sh - trial);
      r.root = {s.root[14:0], 1'b1};
    end else begin
      r.rem  = rem_sh[17:0];
      r.root = {s.root[14:0], 1'b0};
    end
    r.q = {s.q[29:0], 2'b00};
    return r;
  endfunction

endpackage

>>> sv/polar_sector_range_binner_core.sv
// ----------------------------------------------------------------------------
// polar_sector_range_binner_core
// Bins a target position into one of six bearing sectors and reports its
// range there; all other sectors read as not seen.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel (s_*): one word per target, pos_x in the low COORD_WIDTH
//   bits of s_tdata and pos_y above it, both two's complement centimetres.
//   Master channel (m_*): one word per target, six 16-bit ranges. The sector
//   holding the target carries floor(sqrt(x^2 + y^2)), saturated at 65535;
//   the other five carry 65535. A target in no sector gives 65535 in all.
//   Pipeline: 14 register stages from acceptance to m_tvalid.
//   Throughput: one word per cycle while m_tready is high. The depth is set by the
//   16-step restoring square root, two steps per stage over eight stages,
//   behind five stages of capture, abs, squaring/ray products, sums and
//   sector pick, and ahead of the output register.
//   Stalls: each stage has its own valid bit and loads whenever it is empty
//   or the stage after it moves, so bubbles close up while m_tready is low
//   and s_tready only falls once every stage holds a word. Nothing is lost
//   or repeated.
//   Reset (rst, synchronous, active high) empties the pipeline; no other
//   state exists.
// ----------------------------------------------------------------------------
module polar_sector_range_binner_core
  import psrb_pkg::*;
#(
  parameter int COORD_WIDTH = 18
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata, low bit up: pos_x [COORD_WIDTH], pos_y [COORD_WIDTH], zero fill
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata, low bit up: range_front_left, range_front, range_front_right,
  // range_left, range_right, range_rear, 16 bits each
  output logic [OUT_W-1:0]                     m_tdata
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = COORD_WIDTH + 32;        // ray products and cross terms
  localparam int NST = 6 + SQRT_STAGES;         // total register stages
  localparam int SQ0 = 5;                       // first square-root stage index

  // --------------------------------------------------------------------------
  // Per-stage valid bits and elastic handshake
  // --------------------------------------------------------------------------
  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the word
  // --------------------------------------------------------------------------
  logic signed [W-1:0] s1_x;
  logic signed [W-1:0] s1_y;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_x <= signed'(s_tdata[W-1:0]);
      s1_y <= signed'(s_tdata[2*W-1:W]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes. |-2^(W-1)| still fits W unsigned bits.
  // --------------------------------------------------------------------------
  logic signed [W-1:0] s2_x;
  logic [W-1:0]        s2_ax;
  logic [W-1:0]        s2_ay;
  logic                s2_neg;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_x   <= s1_x;
      s2_ax  <= s1_x[W-1] ? W'(~s1_x + 1'b1) : W'(s1_x);
      s2_ay  <= s1_y[W-1] ? W'(~s1_y + 1'b1) : W'(s1_y);
      s2_neg <= s1_y[W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares and the six distinct ray products
  //   p1 = C20*|y|  p2 = S20*x  p3 = C60*|y|  p4 = S60*x  p5 = S20*|y|
  //   p6 = C20*x
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] ay_w;
  logic signed [PW-1:0] x_w;
  logic [2*W-1:0]       s3_sqx;
  logic [2*W-1:0]       s3_sqy;
  logic signed [PW-1:0] s3_p1, s3_p2, s3_p3, s3_p4, s3_p5, s3_p6;
  logic                 s3_neg;

  assign ay_w = PW'(signed'({1'b0, s2_ay}));
  assign x_w  = PW'(s2_x);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_sqx <= s2_ax * s2_ax;
      s3_sqy <= s2_ay * s2_ay;
      s3_p1  <= PW'(K_COS20) * ay_w;
      s3_p2  <= PW'(K_SIN20) * x_w;
      s3_p3  <= PW'(K_COS60) * ay_w;
      s3_p4  <= PW'(K_SIN60) * x_w;
      s3_p5  <= PW'(K_SIN20) * ay_w;
      s3_p6  <= PW'(K_COS20) * x_w;
      s3_neg <= s2_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: radicand with saturation flag, cross terms per boundary ray
  // --------------------------------------------------------------------------
  logic [63:0]          q_sum;
  logic [31:0]          s4_q;
  logic                 s4_sat;
  logic signed [PW-1:0] s4_c20, s4_c60, s4_c70, s4_c110, s4_c160;
  logic                 s4_neg;

  assign q_sum = 64'(s3_sqx) + 64'(s3_sqy);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_q    <= q_sum[31:0];
      s4_sat  <= |q_sum[63:32];
      s4_c20  <= s3_p1 - s3_p2;
      s4_c60  <= s3_p3 - s3_p4;
      s4_c70  <= s3_p5 - s3_p6;
      s4_c110 <= -s3_p5 - s3_p6;
      s4_c160 <= -s3_p1 - s3_p2;
      s4_neg  <= s3_neg;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: sector pick; the side of a ray comes from the sign of its cross
  // term, and the sign of pos_y picks which end of a boundary is inclusive.
  // --------------------------------------------------------------------------
  logic    c20_lt, c20_le, c20_gt, c20_ge;
  logic    c60_le, c70_ge, c110_le, c160_ge;
  sector_t sel_next;
  sector_t s5_sel;
  logic    s5_sat;
  logic [31:0] s5_q;

  always_comb begin
    c20_lt  = s4_c20[PW-1];
    c20_le  = s4_c20[PW-1] || (s4_c20 == '0);
    c20_gt  = !c20_le;
    c20_ge  = !c20_lt;
    c60_le  = s4_c60[PW-1] || (s4_c60 == '0);
    c70_ge  = !s4_c70[PW-1];
    c110_le = s4_c110[PW-1] || (s4_c110 == '0);
    c160_ge = !s4_c160[PW-1];

    if (!s4_neg && c20_gt && c60_le) begin
      sel_next = SEC_FRONT_LEFT;
    end else if (s4_neg ? c20_lt : c20_le) begin
      sel_next = SEC_FRONT;
    end else if (s4_neg && c20_ge && c60_le) begin
      sel_next = SEC_FRONT_RIGHT;
    end else if (!s4_neg && c70_ge && c110_le) begin
      sel_next = SEC_LEFT;
    end else if (s4_neg && c70_ge && c110_le) begin
      sel_next = SEC_RIGHT;
    end else if (c160_ge) begin
      sel_next = SEC_REAR;
    end else begin
      sel_next = SEC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_sel <= sel_next;
      s5_sat <= s4_sat;
      s5_q   <= s4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6..13: restoring square root, two root bits per stage
  // --------------------------------------------------------------------------
  sqrt_t   sq_st  [SQRT_STAGES];
  sector_t sq_sel [SQRT_STAGES];
  logic    sq_sat [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    sqrt_t   st_in;
    sector_t sel_in;
    logic    sat_in;

    if (j == 0) begin : g_first
      assign st_in  = '{rem: '0, root: '0, q: s5_q};
      assign sel_in = s5_sel;
      assign sat_in = s5_sat;
    end else begin : g_rest
      assign st_in  = sq_st[j-1];
      assign sel_in = sq_sel[j-1];
      assign sat_in = sq_sat[j-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[SQ0+j]) begin
        sq_st[j]  <= sqrt_step(sqrt_step(st_in));
        sq_sel[j] <= sel_in;
        sq_sat[j] <= sat_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 14: output register, range steered to its sector
  // --------------------------------------------------------------------------
  logic [RANGE_W-1:0] range_cm;
  logic [RANGE_W-1:0] r_fl, r_f, r_fr, r_l, r_r, r_b;

  assign range_cm = sq_sat[SQRT_STAGES-1] ? SEEN_NONE : sq_st[SQRT_STAGES-1].root;

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      r_fl <= SEEN_NONE;
      r_f  <= SEEN_NONE;
      r_fr <= SEEN_NONE;
      r_l  <= SEEN_NONE;
      r_r  <= SEEN_NONE;
      r_b  <= SEEN_NONE;
      case (sq_sel[SQRT_STAGES-1])
        SEC_FRONT_LEFT:  r_fl <= range_cm;
        SEC_FRONT:       r_f  <= range_cm;
        SEC_FRONT_RIGHT: r_fr <= range_cm;
        SEC_LEFT:        r_l  <= range_cm;
        SEC_RIGHT:       r_r  <= range_cm;
        SEC_REAR:        r_b  <= range_cm;
        default: ;
      endcase
    end
  end

  assign m_tdata = {r_b, r_r, r_l, r_fr, r_f, r_fl};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [N_SECTOR-1:0] seen;
  assign seen = {r_b != SEEN_NONE, r_r != SEEN_NONE, r_l != SEEN_NONE,
                 r_fr != SEEN_NONE, r_f != SEEN_NONE, r_fl != SEEN_NONE};

  a_one_sector: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(seen) <= 1))
    else $error("more than one sector reports a range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v == '1))
    else $error("input stalled while a stage is empty");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v[NST-2] && !rdy[NST-1]) |=> v[NST-2])
    else $error("last square-root stage dropped a word under stall");

endmodule
